@@ rtl/rfc_date_to_epoch_parser_core_macros.svh @@
// Assertion helpers used by the RTL sequencer (rdep_ctrl).
`ifndef RFC_DATE_TO_EPOCH_PARSER_CORE_MACROS_SVH
`define RFC_DATE_TO_EPOCH_PARSER_CORE_MACROS_SVH

// same-cycle implication
`define RDEP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rdep assertion failed");

// next-cycle implication
`define RDEP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rdep assertion failed");

`endif

@@ rtl/rdep_pkg.sv @@
package rdep_pkg;

    localparam int ACC_W = 17;
    localparam logic [ACC_W-1:0] ACC_MAX = 17'd131071;
    localparam logic [ACC_W-1:0] ACC_SAT = 17'd13106;
    localparam logic [ACC_W-1:0] ZONE_NUM_MAX = 17'd9959;
    localparam logic [31:0] DAYS_BIAS = 32'd2472663;  // 32075 + 2440588

    localparam logic [0:35][7:0] MON_TAB = "janfebmaraprmayjunjulaugsepoctnovdec";
    localparam logic [0:29][7:0] ZONE_NAME = "ut gmtestedtcstcdtmstmdtpstpdt";
    localparam logic [1:0] ZONE_LEN [10] = '{2'd2, 2'd3, 2'd3, 2'd3, 2'd3,
                                             2'd3, 2'd3, 2'd3, 2'd3, 2'd3};
    localparam logic signed [13:0] ZONE_OFF [10] = '{14'sd0, 14'sd0, -14'sd300, -14'sd240,
        -14'sd360, -14'sd300, -14'sd420, -14'sd360, -14'sd480, -14'sd420};
    // 367*m/12 for the shifted month, indexed by month number 0..11
    localparam logic [8:0] T367 [12] = '{9'd336, 9'd367, 9'd30, 9'd61, 9'd91, 9'd122,
                                         9'd152, 9'd183, 9'd214, 9'd244, 9'd275, 9'd305};

    typedef enum logic [1:0] {ACC_HOLD, ACC_CLR, ACC_DIG, ACC_ADD} t_acc_op;
    typedef enum logic [2:0] {CV_NONE, CV_TERMS, CV_DAYS, CV_HOUR, CV_MIN, CV_SEC,
                              CV_FIN} t_cv_op;

    typedef struct packed {
        t_acc_op acc_op;
        logic    neg_ld;
        logic    day_ld;
        logic    let0_ld;
        logic    let1_ld;
        logic    mon_ld;
        logic    year_ld;
        logic    year_2000;
        logic    hour_ld;
        logic    hour_zero;
        logic    min_ld;
        logic    min_zero;
        logic    sec_ld;
        logic    sec_zero;
        logic    zn_init;
        logic    zn_step;
        logic    zn_num_ld;
        t_cv_op  cv;
        logic    fin_err;
    } t_dp_cmd;

    typedef struct packed {
        logic zero;
        logic dig;
        logic blank;
        logic colon;
        logic sign_chr;
        logic minus;
        logic day_ok;
        logic year_ok;
        logic hour_ok;
        logic min_ok;
        logic sec_ok;
        logic mon_hit;
        logic zn_big;
        logic zn_done;
    } t_dp_stat;

    function automatic logic [7:0] lower8(input logic [7:0] c);
        return (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
    endfunction

endpackage

@@ rtl/rdep_if.sv @@
interface rdep_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       end_of_string;
    modport source (output valid, char_byte, end_of_string, input ready);
    modport sink (input valid, char_byte, end_of_string, output ready);
endinterface

interface rdep_out_if;
    logic        valid;
    logic        ready;
    logic        date_valid;
    logic [32:0] epoch_seconds;
    modport source (output valid, date_valid, epoch_seconds, input ready);
    modport sink (input valid, date_valid, epoch_seconds, output ready);
endinterface

@@ rtl/rdep_dp.sv @@
module rdep_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_byte,
    input  rdep_pkg::t_dp_cmd i_cmd,
    output rdep_pkg::t_dp_stat o_stat,
    output logic              o_date_valid,
    output logic [32:0]       o_epoch
);
    import rdep_pkg::*;

    logic [ACC_W-1:0] r_acc;
    logic             r_neg;
    logic [4:0]       r_day;
    logic [7:0]       r_let0, r_let1;
    logic [3:0]       r_mon;
    logic [11:0]      r_year;
    logic [4:0]       r_hour;
    logic [5:0]       r_min, r_sec;
    logic signed [13:0] r_zone;
    logic [9:0]       r_cand;
    logic [1:0]       r_zidx;
    logic [21:0]      r_t1;
    logic [8:0]       r_t2;
    logic [6:0]       r_t3;
    logic [31:0]      r_r;
    logic             r_odv;
    logic [32:0]      r_oep;

    logic [7:0]  lc;
    logic [3:0]  dval;
    logic [ACC_W-1:0] acc_next;
    logic [17:0] year_adj;
    logic        acc_nonneg;
    logic [3:0]  mon_idx;
    logic [9:0]  keep;
    logic        hit_any;
    logic signed [13:0] hit_off;
    logic [26:0] zq_prod;
    logic [6:0]  zq;
    logic [6:0]  zrem;
    logic [12:0] zmin;
    logic        a_early;
    logic [12:0] ya, yx;
    logic [23:0] t1_prod;
    logic [25:0] q_prod;
    logic [6:0]  q100;
    logic [8:0]  t3_prod;
    logic signed [33:0] res, off, fin;

    always_comb begin
        lc = lower8(i_byte);
        dval = 4'(i_byte - 8'd48);
        acc_next = (r_acc > ACC_SAT) ? ACC_MAX : ACC_W'(r_acc * 17'd10 + {13'd0, dval});
        acc_nonneg = !r_neg || (r_acc == '0);
        if (r_acc < 17'd50) year_adj = {1'b0, r_acc} + 18'd2000;
        else if (r_acc < 17'd100) year_adj = {1'b0, r_acc} + 18'd1900;
        else year_adj = {1'b0, r_acc};

        o_stat.zero     = i_byte == 8'd0;
        o_stat.dig      = i_byte >= 8'd48 && i_byte <= 8'd57;
        o_stat.blank    = i_byte == 8'd32 || (i_byte >= 8'd9 && i_byte <= 8'd13);
        o_stat.colon    = i_byte == 8'd58;
        o_stat.sign_chr = i_byte == 8'd43 || i_byte == 8'd45;
        o_stat.minus    = i_byte == 8'd45;
        o_stat.day_ok   = r_acc >= 17'd1 && r_acc <= 17'd31;
        o_stat.year_ok  = acc_nonneg && year_adj >= 18'd1900 && year_adj <= 18'd2500;
        o_stat.hour_ok  = acc_nonneg && r_acc <= 17'd23;
        o_stat.min_ok   = acc_nonneg && r_acc <= 17'd59;
        o_stat.sec_ok   = acc_nonneg && r_acc <= 17'd59;
        o_stat.zn_big   = r_acc > ZONE_NUM_MAX;

        o_stat.mon_hit = 1'b0;
        mon_idx = '0;
        for (int k = 0; k < 12; k++) begin
            if (MON_TAB[3*k] == r_let0 && MON_TAB[3*k+1] == r_let1 && MON_TAB[3*k+2] == lc) begin
                o_stat.mon_hit = 1'b1;
                mon_idx = 4'(k);
            end
        end

        for (int k = 0; k < 10; k++) begin
            keep[k] = r_cand[k] && (ZONE_LEN[k] > r_zidx) && r_zidx != 2'd3 &&
                      ZONE_NAME[5'(3*k) + {3'd0, r_zidx}] == lc;
        end
        hit_any = 1'b0;
        hit_off = '0;
        for (int k = 9; k >= 0; k--) begin
            if (keep[k] && ZONE_LEN[k] == r_zidx + 2'd1) begin
                hit_any = 1'b1;
                hit_off = ZONE_OFF[k];
            end
        end
        o_stat.zn_done = (r_zidx == 2'd3) || hit_any || (keep == '0);

        // hhmm to minutes, /100 by reciprocal (exact below 43699)
        zq_prod = 27'(r_acc[13:0] * 27'd5243);
        zq = 7'(zq_prod >> 19);
        zrem = 7'(r_acc[13:0] - 14'(zq * 14'd100));
        zmin = 13'(zq * 13'd60) + {6'd0, zrem};

        a_early = r_mon < 4'd2;
        ya = {1'b0, r_year} + 13'd4800 - {12'd0, a_early};
        yx = {1'b0, r_year} + 13'd4900 - {12'd0, a_early};
        t1_prod = 24'(ya * 24'd1461);
        q_prod = 26'(yx * 26'd5243);
        q100 = 7'(q_prod >> 19);
        t3_prod = 9'(q100 * 9'd3);

        res = signed'({2'b00, r_r});
        off = 34'(r_zone);
        if (off > 0 && off > res) off = '0;
        fin = res - 34'(off * 34'sd60);
        if (fin < 34'sd1) fin = 34'sd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.cv == CV_FIN) begin
            r_acc <= '0; r_neg <= 1'b0; r_day <= '0; r_let0 <= '0; r_let1 <= '0;
            r_mon <= '0; r_year <= '0; r_hour <= '0; r_min <= '0; r_sec <= '0;
            r_zone <= '0; r_cand <= '1; r_zidx <= '0;
        end else begin
            case (i_cmd.acc_op)
                ACC_CLR: r_acc <= '0;
                ACC_DIG: r_acc <= {13'd0, dval};
                ACC_ADD: r_acc <= acc_next;
                default: ;
            endcase
            if (i_cmd.neg_ld) r_neg <= o_stat.minus;
            else if (i_cmd.acc_op == ACC_CLR) r_neg <= 1'b0;
            if (i_cmd.day_ld) r_day <= r_acc[4:0];
            if (i_cmd.let0_ld) r_let0 <= lc;
            if (i_cmd.let1_ld) r_let1 <= lc;
            if (i_cmd.mon_ld) r_mon <= mon_idx;
            if (i_cmd.year_ld) r_year <= year_adj[11:0];
            else if (i_cmd.year_2000) r_year <= 12'd2000;
            if (i_cmd.hour_ld) r_hour <= r_acc[4:0];
            else if (i_cmd.hour_zero) r_hour <= '0;
            if (i_cmd.min_ld) r_min <= r_acc[5:0];
            else if (i_cmd.min_zero) r_min <= '0;
            if (i_cmd.sec_ld) r_sec <= r_acc[5:0];
            else if (i_cmd.sec_zero) r_sec <= '0;
            if (i_cmd.zn_init) begin
                r_cand <= '1;
                r_zidx <= '0;
            end else if (i_cmd.zn_step && r_zidx != 2'd3) begin
                r_cand <= keep;
                if (hit_any) r_zone <= hit_off;
                else r_zidx <= r_zidx + 2'd1;
            end
            if (i_cmd.zn_num_ld) r_zone <= r_neg ? -signed'({1'b0, zmin}) : signed'({1'b0, zmin});
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.cv)
            CV_TERMS: begin
                r_t1 <= t1_prod[23:2];
                r_t2 <= T367[r_mon];
                r_t3 <= t3_prod[8:2];
            end
            CV_DAYS: r_r <= {27'd0, r_day} + {10'd0, r_t1} + {23'd0, r_t2}
                            - {25'd0, r_t3} - DAYS_BIAS;
            CV_HOUR: r_r <= 32'(r_r * 32'd24) + {27'd0, r_hour};
            CV_MIN:  r_r <= 32'(r_r * 32'd60) + {26'd0, r_min};
            CV_SEC:  r_r <= 32'(r_r * 32'd60) + {26'd0, r_sec};
            CV_FIN: begin
                r_odv <= !i_cmd.fin_err;
                r_oep <= i_cmd.fin_err ? '0 : fin[32:0];
            end
            default: ;
        endcase
    end

    assign o_date_valid = r_odv;
    assign o_epoch = r_oep;

endmodule

@@ rtl/rdep_ctrl.sv @@
module rdep_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_eos,
    input  logic               i_out_ready,
    input  rdep_pkg::t_dp_stat i_stat,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output rdep_pkg::t_dp_cmd  o_cmd
);
    import rdep_pkg::*;
    `include "rfc_date_to_epoch_parser_core_macros.svh"

    typedef enum logic [4:0] {
        P_SEEK, P_DAY, P_MSKIP, P_MON1, P_MON2, P_MTAIL, P_YPRE, P_YDIG, P_HPRE, P_HDIG,
        P_NPRE, P_NDIG, P_SPRE, P_SDIG, P_TSKIP, P_ZNUM, P_ZNAME, P_DONE
    } t_phase;
    typedef enum logic [2:0] {S_PARSE, S_TERMS, S_DAYS, S_HOUR, S_MIN, S_SEC, S_FIN} t_state;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic [1:0] r_spaces, n_spaces;
    logic r_sign, n_sign, r_err, n_err, r_out_valid, n_out_valid;
    logic again, e, dg, bl, co, pm, mi, empty, accept;

    always_comb begin
        n_state = r_state; n_phase = r_phase; n_spaces = r_spaces; n_sign = r_sign;
        n_err = r_err; n_out_valid = r_out_valid && !i_out_ready;
        o_cmd = '0;
        again = 1'b0;
        e  = i_eos || i_stat.zero;
        dg = !e && i_stat.dig;
        bl = !e && i_stat.blank;
        co = !e && i_stat.colon;
        pm = !e && i_stat.sign_chr;
        mi = !e && i_stat.minus;
        empty = r_spaces == 2'd0 && !r_sign;
        case (r_state)
            S_PARSE: if (i_in_valid) begin
                case (r_phase)
                    P_SEEK: if (e) begin n_err = 1'b1; n_phase = P_DONE; end
                        else if (dg) begin o_cmd.acc_op = ACC_DIG; n_phase = P_DAY; end
                    P_DAY: if (dg) o_cmd.acc_op = ACC_ADD;
                        else if (e || !i_stat.day_ok) begin n_err = 1'b1; n_phase = P_DONE; end
                        else begin
                            o_cmd.day_ld = 1'b1; n_phase = P_MSKIP; again = !mi;
                        end
                    P_MSKIP: if (e || mi) begin n_err = 1'b1; n_phase = P_DONE; end
                        else if (!bl) begin o_cmd.let0_ld = 1'b1; n_phase = P_MON1; end
                    P_MON1: if (e || mi || bl) begin n_err = 1'b1; n_phase = P_DONE; end
                        else begin o_cmd.let1_ld = 1'b1; n_phase = P_MON2; end
                    P_MON2: if (e || mi || bl || !i_stat.mon_hit) begin
                            n_err = 1'b1; n_phase = P_DONE;
                        end else begin o_cmd.mon_ld = 1'b1; n_phase = P_MTAIL; end
                    P_MTAIL: if (e) begin n_err = 1'b1; n_phase = P_DONE; end
                        else if (mi || bl) begin
                            o_cmd.acc_op = ACC_CLR; n_spaces = '0; n_sign = 1'b0;
                            n_phase = P_YPRE;
                        end
                    P_YPRE, P_HPRE, P_NPRE, P_SPRE: begin
                        if (dg) begin
                            o_cmd.acc_op = ACC_DIG;
                            case (r_phase)
                                P_YPRE:  n_phase = P_YDIG;
                                P_HPRE:  n_phase = P_HDIG;
                                P_NPRE:  n_phase = P_NDIG;
                                default: n_phase = P_SDIG;
                            endcase
                        end else if (bl && !r_sign) begin
                            if (r_spaces != 2'd2) n_spaces = r_spaces + 2'd1;
                        end else if (pm && !r_sign) begin
                            n_sign = 1'b1; o_cmd.neg_ld = 1'b1;
                        end else begin
                            // number without digits
                            case (r_phase)
                                P_YPRE: begin
                                    o_cmd.year_2000 = 1'b1;
                                    if (empty && e) n_phase = P_DONE;
                                    else if (r_spaces == 2'd1 && !r_sign && co) begin
                                        o_cmd.hour_zero = 1'b1; o_cmd.acc_op = ACC_CLR;
                                        n_spaces = '0; n_sign = 1'b0; n_phase = P_NPRE;
                                    end else begin n_err = 1'b1; n_phase = P_DONE; end
                                end
                                P_HPRE: begin
                                    o_cmd.hour_zero = 1'b1;
                                    if (empty && co) begin
                                        o_cmd.acc_op = ACC_CLR; n_spaces = '0; n_sign = 1'b0;
                                        n_phase = P_NPRE;
                                    end else begin n_err = 1'b1; n_phase = P_DONE; end
                                end
                                P_NPRE: begin
                                    o_cmd.min_zero = 1'b1;
                                    if (empty) begin
                                        if (co) begin
                                            o_cmd.acc_op = ACC_CLR; n_spaces = '0;
                                            n_sign = 1'b0; n_phase = P_SPRE;
                                        end else begin n_err = 1'b1; n_phase = P_DONE; end
                                    end else if (r_spaces == 2'd0) begin
                                        n_err = 1'b1; n_phase = P_DONE;
                                    end else if (r_sign) n_phase = P_DONE;
                                    else begin
                                        o_cmd.zn_init = 1'b1; n_phase = P_ZNAME; again = 1'b1;
                                    end
                                end
                                default: begin
                                    o_cmd.sec_zero = 1'b1;
                                    if (r_sign) n_phase = P_DONE;
                                    else begin
                                        o_cmd.zn_init = 1'b1; n_phase = P_ZNAME; again = 1'b1;
                                    end
                                end
                            endcase
                        end
                    end
                    P_YDIG: if (dg) o_cmd.acc_op = ACC_ADD;
                        else if (!i_stat.year_ok) begin n_err = 1'b1; n_phase = P_DONE; end
                        else begin
                            o_cmd.year_ld = 1'b1;
                            if (e) n_phase = P_DONE;
                            else if (!bl) begin n_err = 1'b1; n_phase = P_DONE; end
                            else begin
                                o_cmd.acc_op = ACC_CLR; n_spaces = '0; n_sign = 1'b0;
                                n_phase = P_HPRE;
                            end
                        end
                    P_HDIG: if (dg) o_cmd.acc_op = ACC_ADD;
                        else if (!i_stat.hour_ok || !co) begin n_err = 1'b1; n_phase = P_DONE; end
                        else begin
                            o_cmd.hour_ld = 1'b1; o_cmd.acc_op = ACC_CLR;
                            n_spaces = '0; n_sign = 1'b0; n_phase = P_NPRE;
                        end
                    P_NDIG: if (dg) o_cmd.acc_op = ACC_ADD;
                        else if (!i_stat.min_ok || e) begin n_err = 1'b1; n_phase = P_DONE; end
                        else begin
                            o_cmd.min_ld = 1'b1;
                            if (co) begin
                                o_cmd.acc_op = ACC_CLR; n_spaces = '0; n_sign = 1'b0;
                                n_phase = P_SPRE;
                            end else if (bl) n_phase = P_TSKIP;
                            else begin n_err = 1'b1; n_phase = P_DONE; end
                        end
                    P_SDIG: if (dg) o_cmd.acc_op = ACC_ADD;
                        else if (!i_stat.sec_ok) begin n_err = 1'b1; n_phase = P_DONE; end
                        else begin o_cmd.sec_ld = 1'b1; n_phase = P_TSKIP; again = 1'b1; end
                    P_TSKIP: if (e) n_phase = P_DONE;
                        else if (pm) begin
                            o_cmd.acc_op = ACC_CLR; o_cmd.neg_ld = 1'b1; n_phase = P_ZNUM;
                        end else if (!bl) begin
                            o_cmd.zn_init = 1'b1; n_phase = P_ZNAME; again = 1'b1;
                        end
                    P_ZNUM: if (dg) o_cmd.acc_op = ACC_ADD;
                        else if (i_stat.zn_big) begin n_err = 1'b1; n_phase = P_DONE; end
                        else begin o_cmd.zn_num_ld = 1'b1; n_phase = P_DONE; end
                    P_ZNAME: if (e) n_phase = P_DONE;
                        else begin
                            o_cmd.zn_step = 1'b1;
                            if (i_stat.zn_done) n_phase = P_DONE;
                        end
                    default: ;
                endcase
                if (!again && i_eos) n_state = S_TERMS;
            end
            S_TERMS: begin o_cmd.cv = CV_TERMS; n_state = S_DAYS; end
            S_DAYS:  begin o_cmd.cv = CV_DAYS;  n_state = S_HOUR; end
            S_HOUR:  begin o_cmd.cv = CV_HOUR;  n_state = S_MIN;  end
            S_MIN:   begin o_cmd.cv = CV_MIN;   n_state = S_SEC;  end
            S_SEC:   begin o_cmd.cv = CV_SEC;   n_state = S_FIN;  end
            S_FIN: if (!r_out_valid || i_out_ready) begin
                o_cmd.cv = CV_FIN; o_cmd.fin_err = r_err;
                n_out_valid = 1'b1; n_phase = P_SEEK; n_spaces = '0; n_sign = 1'b0;
                n_err = 1'b0; n_state = S_PARSE;
            end
            default: n_state = S_PARSE;
        endcase
    end

    assign accept = (r_state == S_PARSE) && i_in_valid && !again;
    assign o_in_ready = (r_state == S_PARSE) && !again;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_PARSE; r_phase <= P_SEEK; r_spaces <= '0; r_sign <= 1'b0;
            r_err <= 1'b0; r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state; r_phase <= n_phase; r_spaces <= n_spaces; r_sign <= n_sign;
            r_err <= n_err; r_out_valid <= n_out_valid;
        end
    end

    `RDEP_ASSERT_IMP(a_err_done, r_err, r_phase == P_DONE)
    `RDEP_ASSERT_NXT(a_end_starts, accept && i_eos, r_state == S_TERMS)
    `RDEP_ASSERT_NXT(a_fin_shows, o_cmd.cv == CV_FIN, r_out_valid && r_state == S_PARSE)
    `RDEP_ASSERT_IMP(a_no_take_busy, r_state != S_PARSE, !o_in_ready)

endmodule

@@ rtl/rfc_date_to_epoch_parser_core.sv @@
// Date string to epoch seconds parser.
// i_in carries one character word per handshake: char_byte, or a terminator
// word with end_of_string high (its byte is ignored). A zero byte stops the
// parse like a terminator but gives no result; later bytes are dropped.
// o_out gives one word per terminator: date_valid and epoch_seconds
// (seconds since 1970 UTC, at least 1; zero when the date is not valid).
// Throughput: one character a cycle while ready is high. A byte that closes
// a field and must be looked at again by the next field (day into month,
// seconds into zone, empty number into zone name) holds ready low until
// every field that needs it has looked at it.
// Conversion: after the terminator is taken, the sequencer steps through
// day terms, day sum, hours, minutes, seconds, then zone and clamp; the
// day sum, hours, minutes and seconds build up in one datapath register
// (r_r). No input is taken during those steps.
// A finished result waits in the output register; new characters are
// still taken, and only the next result's last step waits on o_out.ready.
// Reset (synchronous, active low) empties the output and restarts the
// parse at the first digit.
module rfc_date_to_epoch_parser_core (
    input logic       i_clk,
    input logic       i_rst_n,
    rdep_in_if.sink   i_in,
    rdep_out_if.source o_out
);
    import rdep_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencer: parse phase and conversion steps
    rdep_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_eos       (i_in.end_of_string),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    // fields, character classes and the Julian day arithmetic
    rdep_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte       (i_in.char_byte),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_date_valid (o_out.date_valid),
        .o_epoch      (o_out.epoch_seconds)
    );

endmodule

@@ verif/rfc_date_to_epoch_parser_core_tb.sv @@
module rfc_date_to_epoch_parser_core_tb;
    import rdep_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam bit [7:0] CH_SPACE = 8'd32;
    localparam bit [7:0] CH_PLUS = 8'd43;
    localparam bit [7:0] CH_MINUS = 8'd45;
    localparam bit [7:0] CH_COLON = 8'd58;
    localparam int unsigned NUM_SAT = 131071;
    localparam int unsigned ZONE_HHMM_MAX = 9959;

    // parser phases of the local date model
    typedef enum int {
        P_SEEK, P_DAY, P_MSKIP, P_MON1, P_MON2, P_MTAIL,
        P_YPRE, P_YDIG, P_HPRE, P_HDIG, P_NPRE, P_NDIG, P_SPRE, P_SDIG,
        P_TSKIP, P_ZNUM, P_ZNAME, P_DONE
    } t_phase;

    typedef struct {
        bit        date_ok;
        bit [32:0] secs;
    } t_stamp;

    typedef bit [7:0] t_byte_q [$];

    logic i_clk;
    logic i_rst_n;

    rdep_in_if  in_if ();
    rdep_out_if out_if ();

    rfc_date_to_epoch_parser_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if.sink),
        .o_out  (out_if.source)
    );

    // date model state
    t_phase      ph;
    int unsigned acc, day_v, mon_v, year_v, hour_v, min_v, sec_v;
    int unsigned zidx, pfx_spaces;
    bit          acc_neg, err, pfx_sign;
    bit [15:0]   mon_letters;
    bit [9:0]    zone_live;
    int          zone_min;

    string mon_abbrevs = "janfebmaraprmayjunjulaugsepoctnovdec";
    string zone_names [10] = '{"ut", "gmt", "est", "edt", "cst", "cdt",
                               "mst", "mdt", "pst", "pdt"};
    int    zone_offsets [10] = '{0, 0, -300, -240, -360, -300, -420, -360, -480, -420};

    t_stamp pending_dates [$];
    int     errors = 0;
    int     words_sent = 0;
    int     dates_seen = 0;
    int     dates_ok = 0;
    int     cycles = 0;
    int     burst_left = 0;
    int     hold_req = 0;

    function automatic bit is_blank(bit [7:0] c);
        return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit is_dig(bit [7:0] c);
        return c >= 8'd48 && c <= 8'd57;
    endfunction

    function automatic bit [7:0] to_lower(bit [7:0] c);
        return (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
    endfunction

    function automatic void clear_date();
        ph = P_SEEK; acc = 0; acc_neg = 0; day_v = 0; mon_letters = 0; mon_v = 0;
        year_v = 0; hour_v = 0; min_v = 0; sec_v = 0; zone_min = 0;
        zone_live = 10'h3FF; zidx = 0; err = 0; pfx_spaces = 0; pfx_sign = 0;
    endfunction

    function automatic void set_fail();
        err = 1;
        ph = P_DONE;
    endfunction

    function automatic void add_digit(bit [7:0] c);
        if (acc > (NUM_SAT - 9) / 10) acc = NUM_SAT;
        else acc = acc * 10 + (c - 48);
    endfunction

    function automatic void start_num(t_phase p);
        ph = p; acc = 0; acc_neg = 0; pfx_spaces = 0; pfx_sign = 0;
    endfunction

    function automatic void go_zone_name();
        ph = P_ZNAME;
        zone_live = 10'h3FF;
        zidx = 0;
    endfunction

    // number field with no digits; returns 1 when c goes around again
    function automatic bit no_digits(bit [7:0] c, bit fin);
        bit empty;
        empty = pfx_spaces == 0 && !pfx_sign;
        case (ph)
            P_YPRE: begin
                year_v = 2000;
                if (empty && fin) begin
                    ph = P_DONE;
                    return 0;
                end
                if (pfx_spaces == 1 && !pfx_sign && !fin && c == CH_COLON) begin
                    hour_v = 0;
                    start_num(P_NPRE);
                    return 0;
                end
                set_fail();
                return 0;
            end
            P_HPRE: begin
                hour_v = 0;
                if (empty && !fin && c == CH_COLON) start_num(P_NPRE);
                else set_fail();
                return 0;
            end
            P_NPRE: begin
                min_v = 0;
                if (empty) begin
                    if (!fin && c == CH_COLON) start_num(P_SPRE);
                    else set_fail();
                    return 0;
                end
                if (pfx_spaces == 0) begin
                    set_fail();
                    return 0;
                end
                if (pfx_sign) begin
                    ph = P_DONE;
                    return 0;
                end
                go_zone_name();
                return 1;
            end
            default: begin
                sec_v = 0;
                if (pfx_sign) begin
                    ph = P_DONE;
                    return 0;
                end
                go_zone_name();
                return 1;
            end
        endcase
    endfunction

    // digits ended at c; returns 1 when c goes around again
    function automatic bit digits_end(bit [7:0] c, bit fin);
        int v;
        v = acc_neg ? -int'(acc) : int'(acc);
        case (ph)
            P_YDIG: begin
                if (v >= 0 && v < 50) v += 2000;
                else if (v >= 50 && v < 100) v += 1900;
                if (v < 1900 || v > 2500) begin
                    set_fail();
                    return 0;
                end
                year_v = v;
                if (fin) ph = P_DONE;
                else if (!is_blank(c)) set_fail();
                else start_num(P_HPRE);
                return 0;
            end
            P_HDIG: begin
                if (v < 0 || v > 23 || fin || c != CH_COLON) set_fail();
                else begin
                    hour_v = v;
                    start_num(P_NPRE);
                end
                return 0;
            end
            P_NDIG: begin
                if (v < 0 || v > 59 || fin) begin
                    set_fail();
                    return 0;
                end
                min_v = v;
                if (c == CH_COLON) start_num(P_SPRE);
                else if (is_blank(c)) ph = P_TSKIP;
                else set_fail();
                return 0;
            end
            default: begin
                if (v < 0 || v > 59) begin
                    set_fail();
                    return 0;
                end
                sec_v = v;
                ph = P_TSKIP;
                return 1;
            end
        endcase
    endfunction

    function automatic void zone_letter(bit [7:0] c);
        int unsigned idx;
        bit [7:0] lc;
        idx = zidx & 3;
        lc = to_lower(c);
        if (idx > 2) begin
            ph = P_DONE;
            return;
        end
        for (int k = 0; k < 10; k++)
            if (zone_live[k] && (zone_names[k].len() <= idx || zone_names[k][idx] != lc))
                zone_live[k] = 0;
        for (int k = 0; k < 10; k++)
            if (zone_live[k] && zone_names[k].len() == idx + 1) begin
                zone_min = zone_offsets[k];
                ph = P_DONE;
                return;
            end
        if (zone_live == 0) ph = P_DONE;
        else zidx = idx + 1;
    endfunction

    function automatic void parse_char(bit [7:0] c, bit fin);
        bit again;
        int k;
        int m;
        again = 1;
        while (again) begin
            again = 0;
            case (ph)
                P_SEEK: begin
                    if (fin) set_fail();
                    else if (is_dig(c)) begin
                        acc = c - 48;
                        ph = P_DAY;
                    end
                end
                P_DAY: begin
                    if (!fin && is_dig(c)) add_digit(c);
                    else if (fin || acc < 1 || acc > 31) set_fail();
                    else begin
                        day_v = acc;
                        ph = P_MSKIP;
                        again = c != CH_MINUS;
                    end
                end
                P_MSKIP: begin
                    if (fin || c == CH_MINUS) set_fail();
                    else if (!is_blank(c)) begin
                        mon_letters = {8'd0, to_lower(c)};
                        ph = P_MON1;
                    end
                end
                P_MON1, P_MON2: begin
                    if (fin || c == CH_MINUS || is_blank(c)) set_fail();
                    else if (ph == P_MON1) begin
                        mon_letters[15:8] = to_lower(c);
                        ph = P_MON2;
                    end else begin
                        for (k = 0; k < 12; k++)
                            if (mon_abbrevs[3*k] == mon_letters[7:0] &&
                                mon_abbrevs[3*k+1] == mon_letters[15:8] &&
                                mon_abbrevs[3*k+2] == to_lower(c)) break;
                        if (k == 12) set_fail();
                        else begin
                            mon_v = k;
                            ph = P_MTAIL;
                        end
                    end
                end
                P_MTAIL: begin
                    if (fin) set_fail();
                    else if (c == CH_MINUS || is_blank(c)) start_num(P_YPRE);
                end
                P_YPRE, P_HPRE, P_NPRE, P_SPRE: begin
                    if (!fin && is_dig(c)) begin
                        acc = c - 48;
                        ph = t_phase'(ph + 1);
                    end else if (!fin && !pfx_sign && is_blank(c)) begin
                        if (pfx_spaces < 2) pfx_spaces++;
                    end else if (!fin && !pfx_sign && (c == CH_PLUS || c == CH_MINUS)) begin
                        pfx_sign = 1;
                        acc_neg = c == CH_MINUS;
                    end else again = no_digits(c, fin);
                end
                P_YDIG, P_HDIG, P_NDIG, P_SDIG: begin
                    if (!fin && is_dig(c)) add_digit(c);
                    else again = digits_end(c, fin);
                end
                P_TSKIP: begin
                    if (fin) ph = P_DONE;
                    else if (is_blank(c)) ;
                    else if (c == CH_PLUS || c == CH_MINUS) begin
                        acc = 0;
                        acc_neg = c == CH_MINUS;
                        ph = P_ZNUM;
                    end else begin
                        go_zone_name();
                        again = 1;
                    end
                end
                P_ZNUM: begin
                    if (!fin && is_dig(c)) add_digit(c);
                    else if (acc > ZONE_HHMM_MAX) set_fail();
                    else begin
                        m = (acc / 100) * 60 + acc % 100;
                        zone_min = acc_neg ? -m : m;
                        ph = P_DONE;
                    end
                end
                P_ZNAME: begin
                    if (fin) ph = P_DONE;
                    else zone_letter(c);
                end
                default: ;
            endcase
        end
    endfunction

    // one accepted word; returns 1 and the stamp on a terminator
    function automatic bit date_word(bit [7:0] c, bit eos, output t_stamp st);
        longint mon, y, a, days, res, off;
        bit [31:0] r;
        st = '{0, 0};
        if (!eos) begin
            if (c == 0) parse_char(0, 1);
            else parse_char(c, 0);
            return 0;
        end
        if (ph != P_DONE) parse_char(0, 1);
        if (!err) begin
            mon = mon_v + 1;
            y = year_v;
            a = (mon <= 2) ? -1 : 0;
            days = (longint'(day_v) - 32075) + 1461 * (y + 4800 + a) / 4
                 + 367 * (mon - 2 - a * 12) / 12 - 3 * ((y + 4900 + a) / 100) / 4
                 - 2440588;
            r = days[31:0];
            r = 32'd24 * r + hour_v;
            r = 32'd60 * r + min_v;
            r = 32'd60 * r + sec_v;
            res = longint'({32'd0, r});
            off = zone_min;
            if (off > 0 && off > res) off = 0;
            res -= off * 60;
            if (res < 1) res = 1;
            st.date_ok = 1;
            st.secs = res[32:0];
        end
        clear_date();
        return 1;
    endfunction

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout with %0d dates outstanding", $realtime, pending_dates.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: a long hold when asked, else a rotating stall pattern
    initial begin
        int hold;
        hold = 0;
        out_if.ready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                hold = hold_req;
                hold_req = 0;
            end
            if (hold > 0) begin
                hold--;
                out_if.ready = 0;
            end else case ((cycles / 300) % 3)
                0: out_if.ready = 1;
                1: out_if.ready = $urandom_range(0, 3) != 0;
                default: out_if.ready = $urandom_range(0, 3) == 0;
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_stamp want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_dates.size() == 0) begin
                errors++;
                $display("%0t unexpected date word: valid=%0b secs=%0d",
                         $realtime, out_if.date_valid, out_if.epoch_seconds);
            end else begin
                want = pending_dates.pop_front();
                if (out_if.date_valid !== want.date_ok) begin
                    errors++;
                    $display("%0t date_valid expected %0b actual %0b",
                             $realtime, want.date_ok, out_if.date_valid);
                end
                if (out_if.epoch_seconds !== want.secs) begin
                    errors++;
                    $display("%0t epoch_seconds expected %0d actual %0d",
                             $realtime, want.secs, out_if.epoch_seconds);
                end
            end
        end
    end

    // char side: bursts of random length with random gaps in between
    task automatic send_word(bit [7:0] c, bit eos);
        t_stamp st;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 2) != 0) begin
                in_if.valid = 0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end
        end
        in_if.valid = 1;
        in_if.char_byte = c;
        in_if.end_of_string = eos;
        do @(posedge i_clk); while (!in_if.ready);
        burst_left--;
        words_sent++;
        if (date_word(c, eos, st)) begin
            pending_dates.push_back(st);
            dates_seen++;
            if (st.date_ok) dates_ok++;
        end
    endtask

    task automatic send_bytes(t_byte_q q);
        foreach (q[i]) send_word(q[i], 0);
        send_word(8'($urandom_range(0, 255)), 1);
    endtask

    function automatic t_byte_q to_bytes(string s);
        t_byte_q q;
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        return q;
    endfunction

    function automatic string mix_case(string s);
        for (int i = 0; i < s.len(); i++)
            if ($urandom_range(0, 1) && s[i] >= "a" && s[i] <= "z") s[i] = s[i] - 8'd32;
        return s;
    endfunction

    function automatic string rand_date();
        string s, sep;
        int mi;
        int dnum;
        s = "";
        if ($urandom_range(0, 1)) s = "Mon, ";
        dnum = $urandom_range(1, 31);
        if ($urandom_range(0, 19) == 0) s = {s, $sformatf("%0d", $urandom_range(0, 40))};
        else if ($urandom_range(0, 1)) s = {s, $sformatf("%02d", dnum)};
        else s = {s, $sformatf("%0d", dnum)};
        sep = $urandom_range(0, 1) ? " " : "-";
        mi = $urandom_range(0, 11);
        s = {s, sep, mix_case(mon_abbrevs.substr(3*mi, 3*mi+2)), sep};
        if ($urandom_range(0, 1)) s = {s, $sformatf("%02d", $urandom_range(0, 99))};
        else s = {s, $sformatf("%0d", $urandom_range(1880, 2520))};
        if ($urandom_range(0, 4) != 0) begin
            s = {s, $sformatf(" %0d:%02d", $urandom_range(0, 24), $urandom_range(0, 60))};
            if ($urandom_range(0, 1))
                s = {s, $sformatf(":%02d", $urandom_range(0, 60))};
            case ($urandom_range(0, 4))
                0: ;
                1: s = {s, $sformatf(" %s%04d", $urandom_range(0, 1) ? "+" : "-",
                                     $urandom_range(0, 9999))};
                2, 3: s = {s, " ", mix_case(zone_names[$urandom_range(0, 9)])};
                default: s = {s, " ", mix_case(zone_names[$urandom_range(0, 9)].substr(0, 0)),
                              "x"};
            endcase
        end
        return s;
    endfunction

    task automatic do_reset();
        in_if.valid = 0;
        in_if.char_byte = 0;
        in_if.end_of_string = 0;
        i_rst_n = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
    endtask

    task automatic test_directed();
        t_byte_q q;
        send_bytes(to_bytes("Sun, 06 Nov 1994 08:49:37 GMT"));
        send_bytes(to_bytes("6 Nov 94 08:49 +0130"));
        send_bytes(to_bytes("31-dec-2500 23:59:59 -9959"));
        send_bytes(to_bytes("1 JAN 1900 00:00:00 pdt"));
        send_bytes(to_bytes("Thu, 01 Jan 1970 00:00:00 +0100"));   // clamps to one
        send_bytes(to_bytes("01 Jan 70"));
        send_bytes(to_bytes("99999999 Jan 2000"));                 // saturated day
        send_bytes(to_bytes("5 Feb 2020 12:00 +9960"));            // zone too big
        send_bytes(to_bytes("5 xyz 2020"));
        send_bytes(to_bytes(""));
        send_bytes(to_bytes("5 Mar 49 1:2:3 u"));
        send_bytes(to_bytes("5 Mar 50 1:2 zz"));
        send_bytes(to_bytes("7 Jun  "));                           // empty year
        send_bytes(to_bytes("7 Jun - "));
        send_bytes(to_bytes("7 Jul 2001 10: -"));
        send_bytes(to_bytes("8 Aug 2000 10:30: +"));
        send_bytes(to_bytes("8 Sep 2000 10:30 - 5"));
        send_bytes(to_bytes("9 Oct 2030 :5"));
        q = to_bytes("12 Apr 2001 10:00 EST");                     // zero byte stops parse
        q.insert(5, 8'h00);
        q.push_back(8'hFF);
        send_bytes(q);
        q = to_bytes("3 Dec 2001 ");
        q.push_back(8'h80);
        q.push_back(8'h7F);
        send_bytes(q);
    endtask

    task automatic test_random(int target);
        t_byte_q q;
        int start;
        start = words_sent;
        while (words_sent - start < target) begin
            if ($urandom_range(0, 9) == 0) begin
                q.delete();
                repeat ($urandom_range(1, 20)) q.push_back(8'($urandom_range(0, 255)));
            end else begin
                q = to_bytes(rand_date());
                if ($urandom_range(0, 6) == 0)
                    repeat ($urandom_range(1, 2))
                        q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
            end
            send_bytes(q);
        end
    endtask

    // result side blocked for a long while so the parser backs up its input
    task automatic test_backpressure();
        hold_req = 400;
        repeat (8) send_bytes(to_bytes(rand_date()));
    endtask

    initial begin
        clear_date();
        do_reset();
        test_directed();
        test_random(750);
        test_backpressure();
        test_random(600);
        @(negedge i_clk);
        in_if.valid = 0;
        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("%0d words sent, %0d dates checked, %0d parsed as valid",
                 words_sent, dates_seen, dates_ok);
        $display("directed edge strings, random dates with mutation and noise, long output hold");
        if (errors == 0 && pending_dates.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
